FILE: design/scsr_pkg.sv
// shared types and constants for the surface code site role and schedule block
package scsr_pkg;

    localparam int COORD_W = 6;
    localparam int DIST_W  = 7;
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 6;

    // register indexes on the configuration port
    localparam logic REG_DISTANCE = 1'b0;
    localparam logic REG_ORIENT   = 1'b1;

    // orientation codes
    localparam logic [1:0] ORIENT_XV = 2'd0;
    localparam logic [1:0] ORIENT_XH = 2'd1;
    localparam logic [1:0] ORIENT_ZV = 2'd2;
    localparam logic [1:0] ORIENT_ZH = 2'd3;

    // site roles
    localparam logic [1:0] ROLE_EMPTY = 2'd0;
    localparam logic [1:0] ROLE_X     = 2'd1;
    localparam logic [1:0] ROLE_Z     = 2'd2;

    // decoded site, first pipeline stage
    typedef struct packed {
        logic [1:0]         role;
        logic               col_major;
        logic               up_ok;
        logic               here_row_ok;
        logic               left_ok;
        logic               here_col_ok;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIST_W-1:0]  dist_sat;
    } site_t;

    // row bases of the two touched data rows, second pipeline stage
    typedef struct packed {
        logic [1:0]         role;
        logic               col_major;
        logic               up_ok;
        logic               here_row_ok;
        logic               left_ok;
        logic               here_col_ok;
        logic [COORD_W-1:0] col;
        logic [IDX_W-1:0]   base_up;
        logic [IDX_W-1:0]   base_here;
    } rows_t;

endpackage

FILE: design/surface_code_site_role_and_schedule.sv
// top level: rotated surface code site role and cnot schedule lookup
//
// usage
//   - configuration: cfg_we writes cfg_data into register cfg_index at a rising
//     edge (index 0 code distance, index 1 orientation xv/xh/zv/zh); write only
//     while no site is in flight
//   - command: a site (site_row, site_col) transfers at an edge with start high
//     and busy low; busy is never raised, so a site can transfer every cycle
//   - result: done pulses for one cycle with site_role, corner_valid and the
//     four timestep data indices; the receiver cannot stall, so each result is
//     taken in the cycle it is shown
// timing
//   - from the start transfer to done a site passes the registered stages role
//     decode, row base multiply, and column add with zigzag ordering
//   - throughput one site per cycle; the row base multiplier sets stage depth
// reset
//   - rst_n clears all valid bits, distance goes to 3 and orientation to zh;
//     sites in flight are dropped
module surface_code_site_role_and_schedule #(
    parameter int MAX_DISTANCE = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [scsr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [scsr_pkg::COORD_W-1:0] site_row,
    input  logic [scsr_pkg::COORD_W-1:0] site_col,
    output logic                         done,
    output logic [1:0]                   site_role,
    output logic [3:0]                   corner_valid,
    output logic [scsr_pkg::IDX_W-1:0]   step1_data,
    output logic [scsr_pkg::IDX_W-1:0]   step2_data,
    output logic [scsr_pkg::IDX_W-1:0]   step3_data,
    output logic [scsr_pkg::IDX_W-1:0]   step4_data
);
    import scsr_pkg::*;

    logic [CFG_W-1:0] dist_reg;
    logic [1:0]       orient_reg;
    logic             accept;
    logic             s1_valid;
    site_t            s1_site;
    logic             s2_valid;
    rows_t            s2_rows;

    // fully pipelined, every cycle is open for a new site
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg   <= CFG_W'(3);
            orient_reg <= ORIENT_ZH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DISTANCE: dist_reg   <= cfg_data;
                REG_ORIENT:   orient_reg <= cfg_data[1:0];
                default:      dist_reg   <= dist_reg;
            endcase
        end
    end

    // role and boundary decode
    scsr_decode #(
        .MAX_DISTANCE(MAX_DISTANCE)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .dist_cfg  (dist_reg),
        .orient_cfg(orient_reg),
        .row       (site_row),
        .col       (site_col),
        .out_valid (s1_valid),
        .site      (s1_site)
    );

    // row times distance for the two data rows
    scsr_rowmul u_rowmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid),
        .site     (s1_site),
        .out_valid(s2_valid),
        .rows     (s2_rows)
    );

    // corner indices in zigzag order, result registers
    scsr_sched u_sched (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid),
        .rows     (s2_rows),
        .out_valid(done),
        .role     (site_role),
        .mask     (corner_valid),
        .idx1     (step1_data),
        .idx2     (step2_data),
        .idx3     (step3_data),
        .idx4     (step4_data)
    );

`ifndef ASSERT_OFF
    // a result strobe always comes from a matching earlier start
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("done without a matching start");

    // an empty site touches no data qubit
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && site_role == ROLE_EMPTY) |->
            (corner_valid == 4'd0 && step1_data == '0 && step2_data == '0
             && step3_data == '0 && step4_data == '0))
        else $error("empty site with schedule data");

    // a check always touches at least two data qubits, the first or the last corner among them
    a_check_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (done && site_role != ROLE_EMPTY) |->
            ($countones(corner_valid) >= 2 && (corner_valid[0] || corner_valid[3])))
        else $error("check site with too few data qubits");

    // role code three is never produced
    a_role_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (site_role == ROLE_EMPTY || site_role == ROLE_X || site_role == ROLE_Z))
        else $error("undefined role code");
`endif

endmodule

FILE: design/scsr_decode.sv
// stage one: role decode, edge rules and neighbor validity of a site
module scsr_decode #(
    parameter int MAX_DISTANCE = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [scsr_pkg::CFG_W-1:0]   dist_cfg,
    input  logic [1:0]                   orient_cfg,
    input  logic [scsr_pkg::COORD_W-1:0] row,
    input  logic [scsr_pkg::COORD_W-1:0] col,
    output logic                         out_valid,
    output scsr_pkg::site_t              site
);
    import scsr_pkg::*;

    localparam logic [DIST_W-1:0] DMAX = DIST_W'(MAX_DISTANCE);

    logic [DIST_W-1:0]  d_sat;
    logic [DIST_W-1:0]  r_w;
    logic [DIST_W-1:0]  c_w;
    logic               in_grid;
    logic               odd;
    logic               hbe;
    logic               x_even;
    logic               x_top;
    logic               r_in;
    logic               c_in;
    logic               r_edge;
    logic               c_edge;
    logic               is_check;
    logic [1:0]         role;
    logic               valid_reg;
    site_t              site_reg;
    site_t              site_next;

    always_comb
    begin
        d_sat    = ({1'b0, dist_cfg} > DMAX) ? DMAX : {1'b0, dist_cfg};
        r_w      = {1'b0, row};
        c_w      = {1'b0, col};
        in_grid  = (d_sat >= DIST_W'(2)) && (r_w <= d_sat) && (c_w <= d_sat);
        odd      = row[0] ^ col[0];
        hbe      = (orient_cfg == ORIENT_XH) || (orient_cfg == ORIENT_ZH);
        x_even   = (orient_cfg == ORIENT_XV) || (orient_cfg == ORIENT_XH);
        x_top    = (orient_cfg == ORIENT_XV) || (orient_cfg == ORIENT_ZH);
        r_in     = (r_w != '0) && (r_w < d_sat);
        c_in     = (c_w != '0) && (c_w < d_sat);
        r_edge   = (r_w == '0) || (r_w == d_sat);
        c_edge   = (c_w == '0) || (c_w == d_sat);
        // bulk sites always, edge sites on alternate positions
        is_check = in_grid && ((r_in && c_in)
                             || (r_edge && c_in && (odd != hbe))
                             || (c_edge && r_in && (odd == hbe)));
        if (!is_check)
            role = ROLE_EMPTY;
        else if (x_even != odd)
            role = ROLE_X;
        else
            role = ROLE_Z;

        site_next.role        = role;
        site_next.col_major   = (role == ROLE_X) ? x_top : !x_top;
        site_next.up_ok       = is_check && (r_w != '0);
        site_next.here_row_ok = is_check && (r_w < d_sat);
        site_next.left_ok     = is_check && (c_w != '0);
        site_next.here_col_ok = is_check && (c_w < d_sat);
        site_next.row         = row;
        site_next.col         = col;
        site_next.dist_sat    = d_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            site_reg <= site_next;
    end

    assign out_valid = valid_reg;
    assign site      = site_reg;

endmodule

FILE: design/scsr_rowmul.sv
// stage two: row base products for the row above and the site's own row
module scsr_rowmul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  scsr_pkg::site_t site,
    output logic            out_valid,
    output scsr_pkg::rows_t rows
);
    import scsr_pkg::*;

    logic [COORD_W-1:0]        row_up;
    logic [COORD_W+DIST_W-1:0] prod_up;
    logic [COORD_W+DIST_W-1:0] prod_here;
    logic                      valid_reg;
    rows_t                     rows_reg;
    rows_t                     rows_next;

    always_comb
    begin
        row_up    = site.row - COORD_W'(1);
        prod_up   = (COORD_W+DIST_W)'(row_up) * (COORD_W+DIST_W)'(site.dist_sat);
        prod_here = (COORD_W+DIST_W)'(site.row) * (COORD_W+DIST_W)'(site.dist_sat);

        rows_next.role        = site.role;
        rows_next.col_major   = site.col_major;
        rows_next.up_ok       = site.up_ok;
        rows_next.here_row_ok = site.here_row_ok;
        rows_next.left_ok     = site.left_ok;
        rows_next.here_col_ok = site.here_col_ok;
        rows_next.col         = site.col;
        rows_next.base_up     = prod_up[IDX_W-1:0];
        rows_next.base_here   = prod_here[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            rows_reg <= rows_next;
    end

    assign out_valid = valid_reg;
    assign rows      = rows_reg;

endmodule

FILE: design/scsr_sched.sv
// stage three: column add, zigzag ordering and result registers
module scsr_sched (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  scsr_pkg::rows_t            rows,
    output logic                       out_valid,
    output logic [1:0]                 role,
    output logic [3:0]                 mask,
    output logic [scsr_pkg::IDX_W-1:0] idx1,
    output logic [scsr_pkg::IDX_W-1:0] idx2,
    output logic [scsr_pkg::IDX_W-1:0] idx3,
    output logic [scsr_pkg::IDX_W-1:0] idx4
);
    import scsr_pkg::*;

    logic [IDX_W-1:0] col_w;
    logic [IDX_W-1:0] nw_idx;
    logic [IDX_W-1:0] ne_idx;
    logic [IDX_W-1:0] sw_idx;
    logic [IDX_W-1:0] se_idx;
    logic             nw_ok;
    logic             ne_ok;
    logic             sw_ok;
    logic             se_ok;
    logic [3:0]       mask_next;
    logic [IDX_W-1:0] idx1_next;
    logic [IDX_W-1:0] idx2_next;
    logic [IDX_W-1:0] idx3_next;
    logic [IDX_W-1:0] idx4_next;
    logic             valid_reg;
    logic [1:0]       role_reg;
    logic [3:0]       mask_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic [IDX_W-1:0] idx4_reg;

    always_comb
    begin
        col_w  = IDX_W'(rows.col);
        nw_idx = rows.base_up + col_w - IDX_W'(1);
        ne_idx = rows.base_up + col_w;
        sw_idx = rows.base_here + col_w - IDX_W'(1);
        se_idx = rows.base_here + col_w;
        nw_ok  = rows.up_ok && rows.left_ok;
        ne_ok  = rows.up_ok && rows.here_col_ok;
        sw_ok  = rows.here_row_ok && rows.left_ok;
        se_ok  = rows.here_row_ok && rows.here_col_ok;

        // column-major swaps the middle two timesteps
        if (rows.col_major)
        begin
            mask_next = {se_ok, ne_ok, sw_ok, nw_ok};
            idx2_next = sw_ok ? sw_idx : '0;
            idx3_next = ne_ok ? ne_idx : '0;
        end
        else
        begin
            mask_next = {se_ok, sw_ok, ne_ok, nw_ok};
            idx2_next = ne_ok ? ne_idx : '0;
            idx3_next = sw_ok ? sw_idx : '0;
        end
        idx1_next = nw_ok ? nw_idx : '0;
        idx4_next = se_ok ? se_idx : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            role_reg <= rows.role;
            mask_reg <= mask_next;
            idx1_reg <= idx1_next;
            idx2_reg <= idx2_next;
            idx3_reg <= idx3_next;
            idx4_reg <= idx4_next;
        end
    end

    assign out_valid = valid_reg;
    assign role      = role_reg;
    assign mask      = mask_reg;
    assign idx1      = idx1_reg;
    assign idx2      = idx2_reg;
    assign idx3      = idx3_reg;
    assign idx4      = idx4_reg;

endmodule

FILE: dv/surface_code_site_role_and_schedule_tb.sv
// testbench for the surface code site role and cnot schedule lookup block
`timescale 1ns / 1ps

module surface_code_site_role_and_schedule_tb;
    import scsr_pkg::*;

    localparam int MAX_DIST     = 32;
    localparam int DRAIN_CYCLES = 6;       // margin after the last pending result
    localparam int CYCLE_LIMIT  = 100000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_SITES  = 69;

    // one result as the block shows it on its ports
    typedef struct packed {
        logic [1:0]       role;
        logic [3:0]       valid;
        logic [IDX_W-1:0] step1;
        logic [IDX_W-1:0] step2;
        logic [IDX_W-1:0] step3;
        logic [IDX_W-1:0] step4;
    } site_result_t;

    // one row of the directed table; typed rows carry their answer
    typedef struct {
        logic [CFG_W-1:0]   code_dist;
        logic [1:0]         orient;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        bit                 typed;
        site_result_t       want;
    } dir_row_t;

    localparam site_result_t EMPTY_SITE = '0;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    logic [COORD_W-1:0]   site_row;
    logic [COORD_W-1:0]   site_col;
    logic                 done;
    logic [1:0]           site_role;
    logic [3:0]           corner_valid;
    logic [IDX_W-1:0]     step1_data;
    logic [IDX_W-1:0]     step2_data;
    logic [IDX_W-1:0]     step3_data;
    logic [IDX_W-1:0]     step4_data;

    // expectation handed from the driver to the acceptance monitor
    bit                   drv_typed;
    site_result_t         drv_want;
    bit                   took;

    // shadow copy of the two configuration registers
    logic [CFG_W-1:0]     dist_cfg;
    logic [1:0]           orient_cfg;

    site_result_t         pending_sites[$];
    dir_row_t             dir_rows[$];
    int                   errors;
    int                   cycles;
    int                   sites_sent;
    int                   results_seen;
    int                   x_seen;
    int                   z_seen;
    int                   settings_used;

    surface_code_site_role_and_schedule #(
        .MAX_DISTANCE (MAX_DIST)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .site_row     (site_row),
        .site_col     (site_col),
        .done         (done),
        .site_role    (site_role),
        .corner_valid (corner_valid),
        .step1_data   (step1_data),
        .step2_data   (step2_data),
        .step3_data   (step3_data),
        .step4_data   (step4_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // role and cnot schedule of one site under the shadow configuration
    function automatic site_result_t predict_site(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
        site_result_t     res;
        logic [1:0]       role;
        logic [1:0]       bulk_role;
        logic [3:0]       valid;
        logic [IDX_W-1:0] idx [4];
        int               d;
        int               last;
        int               r;
        int               c;
        int               qr;
        int               qc;
        int               off_r;
        int               off_c;
        bit               odd;
        bit               hbe;
        bit               x_even;
        bit               x_top;
        bit               col_major;
        bit               r_in;
        bit               c_in;
        bit               r_edge;
        bit               c_edge;

        d = int'(dist_cfg);
        // distances past the supported maximum behave as the maximum
        if (d > MAX_DIST)
            d = MAX_DIST;
        last   = d;
        r      = int'(row);
        c      = int'(col);
        role   = ROLE_EMPTY;
        valid  = 4'd0;
        odd    = row[0] ^ col[0];
        hbe    = (orient_cfg == ORIENT_XH) || (orient_cfg == ORIENT_ZH);
        x_even = (orient_cfg == ORIENT_XV) || (orient_cfg == ORIENT_XH);
        x_top  = (orient_cfg == ORIENT_XV) || (orient_cfg == ORIENT_ZH);
        r_in   = (r >= 1) && (r <= last - 1);
        c_in   = (c >= 1) && (c <= last - 1);
        r_edge = (r == 0) || (r == last);
        c_edge = (c == 0) || (c == last);
        bulk_role = (x_even != odd) ? ROLE_X : ROLE_Z;

        // tiny codes and sites off the grid stay empty, as do corners
        if (d >= 2 && r <= last && c <= last)
        begin
            if (r_in && c_in)
                role = bulk_role;
            else if (r_edge && c_in && (odd != hbe))
                role = bulk_role;
            else if (c_edge && r_in && (odd == hbe))
                role = bulk_role;
        end

        col_major = (role == ROLE_X) ? x_top : !x_top;
        for (int k = 0; k < 4; k++)
        begin
            // zigzag: row major walks nw, ne, sw, se; column major nw, sw, ne, se
            off_r = (k < 2) ? -1 : 0;
            off_c = (k % 2 == 0) ? -1 : 0;
            if (col_major)
            begin
                off_r = (k % 2 == 0) ? -1 : 0;
                off_c = (k < 2) ? -1 : 0;
            end
            qr = r + off_r;
            qc = c + off_c;
            idx[k] = '0;
            if (role != ROLE_EMPTY && qr >= 0 && qr < d && qc >= 0 && qc < d)
            begin
                valid[k] = 1'b1;
                idx[k]   = IDX_W'(qr * d + qc);
            end
        end

        res.role  = role;
        res.valid = valid;
        res.step1 = idx[0];
        res.step2 = idx[1];
        res.step3 = idx[2];
        res.step4 = idx[3];
        return res;
    endfunction

    function automatic void add_dir(input logic [CFG_W-1:0] code_dist,
                                    input logic [1:0] orient,
                                    input logic [COORD_W-1:0] row,
                                    input logic [COORD_W-1:0] col,
                                    input bit typed, input site_result_t want);
        dir_row_t entry;

        entry.code_dist = code_dist;
        entry.orient    = orient;
        entry.row       = row;
        entry.col       = col;
        entry.typed     = typed;
        entry.want      = want;
        dir_rows = {dir_rows, entry};
    endfunction

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // acceptance monitor and result checker share one edge so the queue
    // is never pushed and popped from two processes in the same step
    always @(posedge clk)
    begin
        site_result_t want;

        if (rst_n && done)
        begin
            results_seen++;
            if (site_role == ROLE_X)
                x_seen++;
            if (site_role == ROLE_Z)
                z_seen++;
            if (pending_sites.size() == 0)
            begin
                $display("%0t ns: result with no site pending, expected nothing, got role %0d",
                         $time, site_role);
                errors++;
            end
            else
            begin
                want = pending_sites.pop_front();
                cmp_field("site_role", want.role, site_role);
                cmp_field("corner_valid", want.valid, corner_valid);
                cmp_field("step1_data", want.step1, step1_data);
                cmp_field("step2_data", want.step2, step2_data);
                cmp_field("step3_data", want.step3, step3_data);
                cmp_field("step4_data", want.step4, step4_data);
            end
        end

        // a site transfers when start is high and busy low
        if (rst_n && start && !busy)
        begin
            sites_sent++;
            if (drv_typed)
                pending_sites = {pending_sites, drv_want};
            else
                pending_sites = {pending_sites, predict_site(site_row, site_col)};
        end
        took <= rst_n && start && !busy;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycles, pending_sites.size());
            $display("surface_code_site_role_and_schedule test failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic drive_site(input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col,
                              input bit typed, input site_result_t want);
        start     <= 1'b1;
        site_row  <= row;
        site_col  <= col;
        drv_typed <= typed;
        drv_want  <= want;
        do
            @(negedge clk);
        while (!took);
    endtask

    // random sender gap: each cycle idle with the given chance in a hundred
    task automatic sender_gap(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // let every pending result come out, then wait out a drain margin
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_sites.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // both registers are written back to back; the block is idle here
    task automatic set_config(input logic [CFG_W-1:0] code_dist, input logic [1:0] orient);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DISTANCE;
        cfg_data  <= code_dist;
        @(negedge clk);
        cfg_index <= REG_ORIENT;
        cfg_data  <= CFG_W'(orient);
        @(negedge clk);
        cfg_we     <= 1'b0;
        dist_cfg   = code_dist;
        orient_cfg = orient;
        settings_used++;
    endtask

    initial
    begin
        int                 pct;
        int                 dsat;
        logic [CFG_W-1:0]   code_dist;
        logic [1:0]         orient;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;

        // every input known from time zero
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DISTANCE;
        cfg_data      = '0;
        start         = 1'b0;
        site_row      = '0;
        site_col      = '0;
        drv_typed     = 1'b0;
        drv_want      = EMPTY_SITE;
        took          = 1'b0;
        dist_cfg      = 6'd3;
        orient_cfg    = ORIENT_ZH;
        errors        = 0;
        cycles        = 0;
        sites_sent    = 0;
        results_seen  = 0;
        x_seen        = 0;
        z_seen        = 0;
        settings_used = 1;

        // directed table: first rows run on the reset values (distance 3, zh)
        add_dir(6'd3, ORIENT_ZH, 6'd0, 6'd0, 1'b1, EMPTY_SITE);          // nw corner
        add_dir(6'd3, ORIENT_ZH, 6'd3, 6'd3, 1'b1, EMPTY_SITE);          // se corner
        add_dir(6'd3, ORIENT_ZH, 6'd1, 6'd1, 1'b1,
                '{ROLE_Z, 4'hF, 10'd0, 10'd1, 10'd3, 10'd4});            // bulk z, row major
        add_dir(6'd3, ORIENT_ZH, 6'd1, 6'd2, 1'b1,
                '{ROLE_X, 4'hF, 10'd1, 10'd4, 10'd2, 10'd5});            // bulk x, col major
        add_dir(6'd3, ORIENT_ZH, 6'd0, 6'd2, 1'b1,
                '{ROLE_Z, 4'hC, 10'd0, 10'd0, 10'd1, 10'd2});            // top edge check
        add_dir(6'd3, ORIENT_ZH, 6'd0, 6'd1, 1'b1, EMPTY_SITE);          // top edge gap
        add_dir(6'd3, ORIENT_ZH, 6'd1, 6'd0, 1'b1,
                '{ROLE_X, 4'hC, 10'd0, 10'd0, 10'd0, 10'd3});            // left edge check
        add_dir(6'd3, ORIENT_ZH, 6'd4, 6'd1, 1'b1, EMPTY_SITE);          // off the grid
        add_dir(6'd3, ORIENT_ZH, 6'd63, 6'd63, 1'b1, EMPTY_SITE);        // all ones
        add_dir(6'd3, ORIENT_ZH, 6'd3, 6'd1, 1'b0, EMPTY_SITE);          // bottom edge
        add_dir(6'd3, ORIENT_ZH, 6'd2, 6'd3, 1'b0, EMPTY_SITE);          // right edge
        add_dir(6'd3, ORIENT_XV, 6'd1, 6'd1, 1'b0, EMPTY_SITE);
        add_dir(6'd3, ORIENT_XV, 6'd0, 6'd1, 1'b0, EMPTY_SITE);
        add_dir(6'd3, ORIENT_XV, 6'd2, 6'd0, 1'b0, EMPTY_SITE);
        add_dir(6'd3, ORIENT_XH, 6'd1, 6'd2, 1'b0, EMPTY_SITE);
        add_dir(6'd3, ORIENT_XH, 6'd3, 6'd2, 1'b0, EMPTY_SITE);
        add_dir(6'd3, ORIENT_ZV, 6'd2, 6'd1, 1'b0, EMPTY_SITE);
        add_dir(6'd3, ORIENT_ZV, 6'd1, 6'd3, 1'b0, EMPTY_SITE);
        add_dir(6'd1, ORIENT_ZV, 6'd1, 6'd1, 1'b1, EMPTY_SITE);          // distance one
        add_dir(6'd0, ORIENT_XH, 6'd0, 6'd0, 1'b1, EMPTY_SITE);          // distance zero
        add_dir(6'd2, ORIENT_XV, 6'd1, 6'd1, 1'b0, EMPTY_SITE);          // smallest code
        add_dir(6'd2, ORIENT_XV, 6'd0, 6'd1, 1'b0, EMPTY_SITE);
        add_dir(6'd32, ORIENT_ZH, 6'd31, 6'd32, 1'b0, EMPTY_SITE);       // top data index
        add_dir(6'd32, ORIENT_ZH, 6'd16, 6'd16, 1'b0, EMPTY_SITE);
        add_dir(6'd32, ORIENT_ZH, 6'd33, 6'd1, 1'b1, EMPTY_SITE);        // just off the grid
        add_dir(6'd63, ORIENT_XV, 6'd32, 6'd31, 1'b0, EMPTY_SITE);       // saturated distance
        add_dir(6'd63, ORIENT_XV, 6'd33, 6'd33, 1'b1, EMPTY_SITE);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, back to back; configuration changes only once drained
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].code_dist != dist_cfg || dir_rows[i].orient != orient_cfg)
            begin
                wait_drained();
                set_config(dir_rows[i].code_dist, dir_rows[i].orient);
            end
            drive_site(dir_rows[i].row, dir_rows[i].col, dir_rows[i].typed,
                       dir_rows[i].want);
        end

        // random phases: each one its own setting and one of three sender patterns;
        // the receiver cannot hold results off, so no phase stalls the results
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: code_dist = 6'd32;
                1: code_dist = 6'd7;
                2: code_dist = 6'd2;
                3: code_dist = 6'd63;
                4: code_dist = 6'd4;
                5: code_dist = 6'd1;
                6: code_dist = 6'd33;
                default: code_dist = CFG_W'($urandom_range(3, 31));
            endcase
            orient = 2'((ph + ph / 4) % 4);
            case (ph % 4)
                1: pct = 82;
                3: pct = 17;
                default: pct = 0;
            endcase
            dsat = (int'(code_dist) > MAX_DIST) ? MAX_DIST : int'(code_dist);

            wait_drained();
            set_config(code_dist, orient);
            for (int n = 0; n < PHASE_SITES; n++)
            begin
                sender_gap(pct);
                // mostly sites on the grid, some anywhere in the coordinate range
                if ($urandom_range(0, 99) < 85)
                begin
                    row = COORD_W'($urandom_range(0, dsat));
                    col = COORD_W'($urandom_range(0, dsat));
                end
                else
                begin
                    row = COORD_W'($urandom_range(0, 63));
                    col = COORD_W'($urandom_range(0, 63));
                end
                drive_site(row, col, 1'b0, EMPTY_SITE);
            end
        end

        wait_drained();

        $display("sent %0d sites under %0d register settings, checked %0d results",
                 sites_sent, settings_used, results_seen);
        $display("results held %0d x checks and %0d z checks; %0d mismatches",
                 x_seen, z_seen, errors);
        if (errors == 0 && pending_sites.size() == 0)
            $display("surface_code_site_role_and_schedule test passed");
        else
            $display("surface_code_site_role_and_schedule test failed");
        $finish;
    end

endmodule

FILE: files.f
design/scsr_pkg.sv
design/scsr_decode.sv
design/scsr_rowmul.sv
design/scsr_sched.sv
design/surface_code_site_role_and_schedule.sv
dv/surface_code_site_role_and_schedule_tb.sv
